// ----- rtl/stochastic_oscillator_alert_defines.svh -----
// ----------------------------------------------------------------------------
// stochastic oscillator alert: assertion macros
// checks with the block clock and reset, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef STOCHASTIC_OSCILLATOR_ALERT_DEFINES_SVH
`define STOCHASTIC_OSCILLATOR_ALERT_DEFINES_SVH
`ifndef SYNTHESIS
// property checked outside of reset
`define SOA_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked at every edge, reset included
`define SOA_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SOA_ASSERT(name, prop, msg)
`define SOA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- rtl/sto_pkg.sv -----
// ----------------------------------------------------------------------------
// sto_pkg
// shared types and constants of the stochastic oscillator alert block
// ----------------------------------------------------------------------------
package sto_pkg;

   // fixed field widths
   localparam int K_W        = 15;
   localparam int QUOT_W     = 15;
   localparam int DIV_CNT_W  = 4;
   localparam int PERIOD_W   = 7;
   localparam int SMOOTH_W   = 5;
   localparam int LINE_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int RSP_W      = 40;

   localparam logic [K_W-1:0] FULL_SCALE = K_W'(25600);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PERIOD    = 3'd0,
      REG_K_SMOOTH  = 3'd1,
      REG_D_SMOOTH  = 3'd2,
      REG_BUY_LINE  = 3'd3,
      REG_SELL_LINE = 3'd4
   } csr_reg_type;

   // alert codes
   typedef enum logic [1:0] {
      ALERT_NONE = 2'd0,
      ALERT_BUY  = 2'd1,
      ALERT_SELL = 2'd2
   } alert_type;

   // which value is in flight
   typedef enum logic [1:0] {
      STG_RAW,
      STG_K,
      STG_D
   } stg_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_RAW,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_AVG,
      ST_SUM,
      ST_ADV,
      ST_ALERT,
      ST_OUT
   } state_type;

   // controls of the window cells
   typedef struct packed {
      logic shift;
      logic load;
      logic step;
   } cell_ctl_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/sto_cell.sv -----
// ----------------------------------------------------------------------------
// sto_cell
// one window slot: holds a bar high and low, and a running max/min that
// takes its neighbor's running value one step per cycle during a scan
// ----------------------------------------------------------------------------
module sto_cell
   import sto_pkg::*;
#(
   parameter int PRICE_BITS = 32
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic                  tail,
   input  logic [PRICE_BITS-1:0] shift_hi,
   input  logic [PRICE_BITS-1:0] shift_lo,
   input  logic [PRICE_BITS-1:0] nbr_max,
   input  logic [PRICE_BITS-1:0] nbr_min,
   output logic [PRICE_BITS-1:0] own_hi,
   output logic [PRICE_BITS-1:0] own_lo,
   output logic [PRICE_BITS-1:0] acc_max,
   output logic [PRICE_BITS-1:0] acc_min
);

   logic [PRICE_BITS-1:0] hi_ff, lo_ff, max_ff, min_ff;
   logic [PRICE_BITS-1:0] max_in, min_in;

   // running extremes: own values merged with the neighbor's
   always_comb begin
      max_in = max_ff;
      min_in = min_ff;
      if (ctl.load) begin
         max_in = hi_ff;
         min_in = lo_ff;
      end else if (ctl.step && !tail) begin
         max_in = (nbr_max > hi_ff) ? nbr_max : hi_ff;
         min_in = (nbr_min < lo_ff) ? nbr_min : lo_ff;
      end
   end

   // window slot and running value
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         hi_ff <= shift_hi;
         lo_ff <= shift_lo;
      end
      max_ff <= max_in;
      min_ff <= min_in;
   end

   assign own_hi  = hi_ff;
   assign own_lo  = lo_ff;
   assign acc_max = max_ff;
   assign acc_min = min_ff;

endmodule

// ----- rtl/sto_div.sv -----
// ----------------------------------------------------------------------------
// sto_div
// restoring divider, one quotient bit per cycle; the quotient must fit in
// QUOT_W bits (numerator below denominator shifted up by QUOT_W)
// ----------------------------------------------------------------------------
module sto_div
   import sto_pkg::*;
#(
   parameter int DEN_W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DEN_W+QUOT_W-1:0] numer,
   input  logic [DEN_W-1:0]        denom,
   output div_stat_type            stat,
   output logic [QUOT_W-1:0]       quot
);

   logic                 busy_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]     rem_ff, den_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [DEN_W:0]       trial;

   // one trial subtract
   always_comb begin
      trial = {rem_ff, quo_ff[QUOT_W-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = DEN_W'(trial - {1'b0, den_ff});
         quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DEN_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer[DEN_W+QUOT_W-1:QUOT_W];
         quo_ff <= numer[QUOT_W-1:0];
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quo_ff;

endmodule

// ----- rtl/stochastic_oscillator_alert.sv -----
// ----------------------------------------------------------------------------
// stochastic_oscillator_alert
// slow stochastic %K/%D over a window of price bars, with buy/sell alert
// ----------------------------------------------------------------------------
// Requests on req_ carry one price bar (high, low, close). Each request gives
// exactly one result on rsp_: %K and %D in percent times 256 with their
// warm-up flags, and the held alert state.
// The csr_ channel writes period, k_smoothing, d_smoothing, buy_line and
// sell_line by index; it is always ready. The user must make writes while
// idle; the block itself does not enforce this. Bars still in warm-up and
// zero lengths skip some of the steps. A chain of window cells merges max/min
// one cell per cycle, then one shared 15-step divider serves raw %K and both
// averages, and the averages are summed one entry a cycle. One bar is worked
// on at a time; the next request is taken in the same cycle that the result
// is in the output register.
// Reset restores the default registers and clears counters and alert state;
// window contents are not cleared. When rsp_tready is low, the result holds
// in the output register and the block may still work on the next bar.
// ----------------------------------------------------------------------------
module stochastic_oscillator_alert
   import sto_pkg::*;
#(
   parameter int MAX_PERIOD = 64,
   parameter int MAX_SMOOTH = 16,
   parameter int PRICE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // bar_high, bar_low, bar_close, zero fill
   input  logic [((3*PRICE_BITS+7)/8)*8-1:0]       req_tdata,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // k_value, k_valid, d_value, d_valid, alert_state, alert_valid, zero fill
   output logic [RSP_W-1:0]                        rsp_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [CSR_IDX_W-1:0]                    csr_index,
   input  logic [CSR_DATA_W-1:0]                   csr_data
);

`include "stochastic_oscillator_alert_defines.svh"

   localparam int P_W    = $clog2(MAX_PERIOD + 2);
   localparam int PC_W   = (P_W > PERIOD_W) ? P_W : PERIOD_W;
   localparam int L_W    = $clog2(MAX_SMOOTH + 1);
   localparam int LC_W   = (L_W > SMOOTH_W) ? L_W : SMOOTH_W;
   localparam int IDX_W  = (MAX_SMOOTH > 1) ? $clog2(MAX_SMOOTH) : 1;
   localparam int SUM_W  = K_W + L_W;
   localparam int NUM_W  = PRICE_BITS + QUOT_W;
   localparam int KV_BIT = K_W;
   localparam int DV_BIT = 2 * K_W + 1;

   // configuration registers
   logic [PERIOD_W-1:0] period_ff;
   logic [SMOOTH_W-1:0] k_smooth_ff, d_smooth_ff;
   logic [LINE_W-1:0]   buy_line_ff, sell_line_ff;

   // sequencer state
   state_type            state_ff, state_in;
   stg_type              stg_ff, stg_in;
   logic [P_W-1:0]       bars_ff, bars_in, scan_cnt_ff, scan_cnt_in;
   logic [PRICE_BITS-1:0] close_ff, close_in;
   logic [K_W-1:0]       cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [L_W-1:0]       kcnt_ff, kcnt_in, dcnt_ff, dcnt_in, idx_ff, idx_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [PRICE_BITS-1:0] den_ff, den_in;
   logic [K_W-1:0]       k_ff, k_in, d_ff, d_in, prev_d_ff, prev_d_in;
   logic                 kv_ff, kv_in, dv_ff, dv_in, have_ff, have_in;
   alert_type            alert_ff, alert_in;
   logic [1:0]           dseen_ff, dseen_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kshift, dshift, div_start;

   // effective lengths
   logic [PC_W-1:0]      period_x;
   logic [P_W-1:0]       p_eff, p1;
   logic [LC_W-1:0]      k_smooth_x, d_smooth_x;
   logic [L_W-1:0]       k_len, d_len, len_sel, cnt_sel, cnt_cut, cnt_up;
   logic [K_W-1:0]       win_rd;

   // windows of the two averages, newest first
   logic [K_W-1:0]       kwin_ff [MAX_SMOOTH];
   logic [K_W-1:0]       dwin_ff [MAX_SMOOTH];

   // cell chain
   cell_ctl_type          cell_ctl;
   logic                  tail_w   [MAX_PERIOD];
   logic [PRICE_BITS-1:0] own_hi_w [MAX_PERIOD];
   logic [PRICE_BITS-1:0] own_lo_w [MAX_PERIOD];
   logic [PRICE_BITS-1:0] acc_max_w[MAX_PERIOD];
   logic [PRICE_BITS-1:0] acc_min_w[MAX_PERIOD];
   logic [PRICE_BITS-1:0] bar_high, bar_low, bar_close;
   logic [PRICE_BITS-1:0] win_max, win_min, diff;

   // divider
   div_stat_type          div_stat;
   logic [QUOT_W-1:0]     div_quot;

   logic buy_c, sell_c, have_after;
   logic [1:0] dseen_up;

   assign bar_high  = req_tdata[PRICE_BITS-1:0];
   assign bar_low   = req_tdata[2*PRICE_BITS-1:PRICE_BITS];
   assign bar_close = req_tdata[3*PRICE_BITS-1:2*PRICE_BITS];

   // clamp configured lengths to the supported range
   assign period_x   = PC_W'(period_ff);
   assign p_eff      = (period_ff == '0) ? P_W'(1) :
                       (period_x > PC_W'(MAX_PERIOD)) ? P_W'(MAX_PERIOD) : P_W'(period_x);
   assign p1         = p_eff + 1'b1;
   assign k_smooth_x = LC_W'(k_smooth_ff);
   assign d_smooth_x = LC_W'(d_smooth_ff);
   assign k_len      = (k_smooth_x > LC_W'(MAX_SMOOTH)) ? L_W'(MAX_SMOOTH) : L_W'(k_smooth_x);
   assign d_len      = (d_smooth_x > LC_W'(MAX_SMOOTH)) ? L_W'(MAX_SMOOTH) : L_W'(d_smooth_x);

   // selected average stage
   assign len_sel = (stg_ff == STG_K) ? k_len : d_len;
   assign cnt_sel = (stg_ff == STG_K) ? kcnt_ff : dcnt_ff;
   assign cnt_cut = (cnt_sel > len_sel) ? len_sel : cnt_sel;
   assign cnt_up  = (cnt_cut < len_sel) ? cnt_cut + 1'b1 : cnt_cut;
   assign win_rd  = (stg_ff == STG_K) ? kwin_ff[idx_ff[IDX_W-1:0]] : dwin_ff[idx_ff[IDX_W-1:0]];

   // window extremes come out of the first cell
   assign win_max = acc_max_w[0];
   assign win_min = acc_min_w[0];
   assign diff    = close_ff - win_min;

   // alert conditions on the new %D
   assign buy_c      = (d_ff <= {buy_line_ff, 8'b0}) && (d_ff > prev_d_ff);
   assign sell_c     = (d_ff >= {sell_line_ff, 8'b0}) && (d_ff < prev_d_ff);
   assign have_after = have_ff | dv_ff;
   assign dseen_up   = (dv_ff && dseen_ff < 2'd2) ? dseen_ff + 1'b1 : dseen_ff;

   // cell chain: bars shift toward higher cells, running max/min toward cell 0
   for (genvar i = 0; i < MAX_PERIOD; i++) begin : g_cell
      logic [PRICE_BITS-1:0] sh_hi, sh_lo, nb_max, nb_min;
      if (i == 0) begin : g_head
         assign sh_hi = bar_high;
         assign sh_lo = bar_low;
      end else begin : g_body
         assign sh_hi = own_hi_w[i-1];
         assign sh_lo = own_lo_w[i-1];
      end
      if (i == MAX_PERIOD - 1) begin : g_end
         assign nb_max = acc_max_w[i];
         assign nb_min = acc_min_w[i];
      end else begin : g_mid
         assign nb_max = acc_max_w[i+1];
         assign nb_min = acc_min_w[i+1];
      end
      assign tail_w[i] = (P_W'(i + 1) >= p_eff);

      sto_cell #(
         .PRICE_BITS (PRICE_BITS)
      ) u_cell (
         .clock    (clock),
         .ctl      (cell_ctl),
         .tail     (tail_w[i]),
         .shift_hi (sh_hi),
         .shift_lo (sh_lo),
         .nbr_max  (nb_max),
         .nbr_min  (nb_min),
         .own_hi   (own_hi_w[i]),
         .own_lo   (own_lo_w[i]),
         .acc_max  (acc_max_w[i]),
         .acc_min  (acc_min_w[i])
      );
   end

   // shared divider
   sto_div #(
      .DEN_W (PRICE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_ff),
      .denom (den_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_W'(14);
         k_smooth_ff  <= SMOOTH_W'(3);
         d_smooth_ff  <= SMOOTH_W'(3);
         buy_line_ff  <= LINE_W'(20);
         sell_line_ff <= LINE_W'(80);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_PERIOD:    period_ff    <= csr_data[PERIOD_W-1:0];
            REG_K_SMOOTH:  k_smooth_ff  <= csr_data[SMOOTH_W-1:0];
            REG_D_SMOOTH:  d_smooth_ff  <= csr_data[SMOOTH_W-1:0];
            REG_BUY_LINE:  buy_line_ff  <= csr_data[LINE_W-1:0];
            REG_SELL_LINE: sell_line_ff <= csr_data[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      stg_in       = stg_ff;
      bars_in      = bars_ff;
      scan_cnt_in  = scan_cnt_ff;
      close_in     = close_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      kcnt_in      = kcnt_ff;
      dcnt_in      = dcnt_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      k_in         = k_ff;
      kv_in        = kv_ff;
      d_in         = d_ff;
      dv_in        = dv_ff;
      prev_d_in    = prev_d_ff;
      have_in      = have_ff;
      alert_in     = alert_ff;
      dseen_in     = dseen_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;
      cell_ctl     = '0;
      kshift       = 1'b0;
      dshift       = 1'b0;
      div_start    = 1'b0;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cell_ctl.shift = 1'b1;
               close_in       = bar_close;
               stg_in         = STG_RAW;
               if (bars_ff > p1) begin
                  bars_in = p1;
               end else if (bars_ff < p1) begin
                  bars_in = bars_ff + 1'b1;
               end
               if (bars_in >= p1) begin
                  state_in = ST_LOAD;
               end else begin
                  cur_in       = '0;
                  cur_valid_in = 1'b0;
                  state_in     = ST_ADV;
               end
            end
         end
         ST_LOAD: begin
            cell_ctl.load = 1'b1;
            scan_cnt_in   = P_W'(1);
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == p_eff) begin
               state_in = ST_RAW;
            end else begin
               cell_ctl.step = 1'b1;
               scan_cnt_in   = scan_cnt_ff + 1'b1;
            end
         end
         ST_RAW: begin
            cur_valid_in = 1'b1;
            if (win_max <= win_min || close_ff <= win_min) begin
               cur_in   = '0;
               state_in = ST_ADV;
            end else if (close_ff >= win_max) begin
               cur_in   = FULL_SCALE;
               state_in = ST_ADV;
            end else begin
               // times 25600 as shifts: 16384 + 8192 + 1024
               num_in   = (NUM_W'(diff) << 14) + (NUM_W'(diff) << 13) + (NUM_W'(diff) << 10);
               den_in   = win_max - win_min;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               cur_in   = div_quot;
               state_in = ST_ADV;
            end
         end
         ST_AVG: begin
            if (len_sel == '0) begin
               state_in = ST_ADV;
            end else if (!cur_valid_ff) begin
               if (stg_ff == STG_K) kcnt_in = cnt_cut;
               else dcnt_in = cnt_cut;
               cur_in   = '0;
               state_in = ST_ADV;
            end else begin
               if (stg_ff == STG_K) begin
                  kshift  = 1'b1;
                  kcnt_in = cnt_up;
               end else begin
                  dshift  = 1'b1;
                  dcnt_in = cnt_up;
               end
               if (cnt_up < len_sel) begin
                  cur_in       = '0;
                  cur_valid_in = 1'b0;
                  state_in     = ST_ADV;
               end else begin
                  sum_in   = '0;
                  idx_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (idx_ff == len_sel) begin
               num_in   = NUM_W'(sum_ff);
               den_in   = PRICE_BITS'(len_sel);
               state_in = ST_DIV_GO;
            end else begin
               sum_in = sum_ff + SUM_W'(win_rd);
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_ADV: begin
            case (stg_ff)
               STG_K: begin
                  k_in     = cur_ff;
                  kv_in    = cur_valid_ff;
                  stg_in   = STG_D;
                  state_in = ST_AVG;
               end
               STG_D: begin
                  d_in     = cur_ff;
                  dv_in    = cur_valid_ff;
                  state_in = ST_ALERT;
               end
               default: begin
                  stg_in   = STG_K;
                  state_in = ST_AVG;
               end
            endcase
         end
         ST_ALERT: begin
            if (dv_ff) begin
               if (have_ff) begin
                  if (buy_c && alert_ff != ALERT_BUY) alert_in = ALERT_BUY;
                  else if (sell_c && alert_ff != ALERT_SELL) alert_in = ALERT_SELL;
               end
               prev_d_in = d_ff;
               have_in   = 1'b1;
            end
            // a fresh start after reset forgets earlier %D values
            if (bars_ff == P_W'(1) && !dv_ff && !kv_ff && !have_after) dseen_in = 2'd0;
            else dseen_in = dseen_up;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = RSP_W'({dseen_in >= 2'd2, alert_ff, dv_ff, d_ff, kv_ff, k_ff});
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stg_ff       <= STG_RAW;
         bars_ff      <= '0;
         scan_cnt_ff  <= '0;
         cur_valid_ff <= 1'b0;
         kcnt_ff      <= '0;
         dcnt_ff      <= '0;
         idx_ff       <= '0;
         kv_ff        <= 1'b0;
         dv_ff        <= 1'b0;
         prev_d_ff    <= '0;
         have_ff      <= 1'b0;
         alert_ff     <= ALERT_NONE;
         dseen_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stg_ff       <= stg_in;
         bars_ff      <= bars_in;
         scan_cnt_ff  <= scan_cnt_in;
         cur_valid_ff <= cur_valid_in;
         kcnt_ff      <= kcnt_in;
         dcnt_ff      <= dcnt_in;
         idx_ff       <= idx_in;
         kv_ff        <= kv_in;
         dv_ff        <= dv_in;
         prev_d_ff    <= prev_d_in;
         have_ff      <= have_in;
         alert_ff     <= alert_in;
         dseen_ff     <= dseen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      close_ff    <= close_in;
      cur_ff      <= cur_in;
      sum_ff      <= sum_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      k_ff        <= k_in;
      d_ff        <= d_in;
      rsp_data_ff <= rsp_data_in;
   end

   // average windows shift in the value entering their stage
   always_ff @(posedge clock) begin
      if (kshift) begin
         kwin_ff[0] <= cur_ff;
         for (int i = 1; i < MAX_SMOOTH; i++) kwin_ff[i] <= kwin_ff[i-1];
      end
      if (dshift) begin
         dwin_ff[0] <= cur_ff;
         for (int i = 1; i < MAX_SMOOTH; i++) dwin_ff[i] <= dwin_ff[i-1];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // checks
   `SOA_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_tvalid), "reset did not idle the block")
   `SOA_ASSERT(a_div_free, (div_start || state_ff == ST_IDLE) |-> !div_stat.busy, "divider busy out of turn")
   `SOA_ASSERT(a_scan_bound, (state_ff == ST_SCAN) |-> (scan_cnt_ff <= p_eff), "scan ran past the window")
   `SOA_ASSERT(a_d_needs_k, (rsp_tvalid && rsp_tdata[DV_BIT]) |-> rsp_tdata[KV_BIT], "valid d without valid k")

endmodule
